// ===== rtl/gclp_pkg.sv =====
// Shared constants and types of the G-code line parser.
`default_nettype none

package gclp_pkg;

	// Widths of the result fields.
	localparam int CODE_W = 12;
	localparam int ARG_W = 32;
	localparam int MASK_W = 12;
	localparam int VAL_W = 17;
	localparam int CNT_W = 3;
	localparam int PT_W = 4;

	// Default nozzle count.
	localparam int NOZZLES_DEF = 12;

	typedef logic [ARG_W-1:0] arg_word_t;
	typedef logic signed [CODE_W-1:0] code_t;

	// Command code constants.
	localparam int G_OFFSET = 1000;
	localparam int NOZZLE_LINE_CODE = 2000;
	localparam int DIR0_DROP = 2;
	localparam int DIR1_DROP = 3;

	// Line kinds.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NOZZLE = 2'd1;
	localparam logic [1:0] KIND_G = 2'd2;
	localparam logic [1:0] KIND_M = 2'd3;

	// Digit count limits per word class.
	localparam logic [CNT_W-1:0] LIM_CODE = 3'd3;
	localparam logic [CNT_W-1:0] LIM_FLAG = 3'd1;
	localparam logic [CNT_W-1:0] LIM_DEC = 3'd5;

	// Point position meaning that no point was seen.
	localparam logic [PT_W-1:0] NO_POINT = 4'd15;

	// Characters.
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_J = 8'h4A;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_X = 8'h58;
	localparam logic [7:0] CH_Y = 8'h59;
	localparam logic [7:0] CH_Z = 8'h5A;

endpackage

`default_nettype wire

// ===== rtl/gcode_line_parser.sv =====
// G-code line parser: characters in, one command record per line out.
//
// Usage. Characters arrive on the input channel (in_valid / in_ready, payload func and
// char_in), one transaction per character. func high marks end of stream and closes the
// line like a newline does. Command records leave on the output channel (out_valid /
// out_ready) with the code, six tagged argument words and the nozzle mask.
// Throughput is one character per cycle while in_ready is high. Each character passes
// combinationally into the parser state; a newline or end-of-stream transaction loads
// the output register, so its record is shown in the cycle after acceptance.
// The output register parts the two sides: while a record waits, the parser still takes
// a character in the same cycle the record is taken (in_ready follows out_ready). Only
// when a record waits and out_ready is low does in_ready drop; nothing is lost.
// Reset (arst_n low, asynchronous) clears the open word, the line record, the selected
// nozzles and the remembered nozzle on-mask, and empties the output register.
`default_nettype none

module gcode_line_parser #(
	parameter int NOZZLES = gclp_pkg::NOZZLES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               func,
	input  wire  [7:0]                        char_in,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [gclp_pkg::CODE_W-1:0] command_code,
	output gclp_pkg::arg_word_t               arg_word_1,
	output gclp_pkg::arg_word_t               arg_word_2,
	output gclp_pkg::arg_word_t               arg_word_3,
	output gclp_pkg::arg_word_t               arg_word_4,
	output gclp_pkg::arg_word_t               arg_word_5,
	output gclp_pkg::arg_word_t               arg_word_6,
	output logic [gclp_pkg::MASK_W-1:0]       nozzle_mask
);

	localparam int VW = gclp_pkg::VAL_W;
	localparam int CW = gclp_pkg::CNT_W;
	localparam int PW = gclp_pkg::PT_W;
	localparam int KW = gclp_pkg::CODE_W;
	localparam int MW = gclp_pkg::MASK_W;

	// Parser state: the open word and the line being built.
	logic [7:0]           letter_q;
	logic                 viol_q;
	logic [1:0]           kind_q;
	logic [VW-1:0]        dval_q;
	logic [CW-1:0]        dcnt_q;
	logic [PW-1:0]        point_q;
	logic                 minus_q;
	logic [KW-1:0]        code_q;
	gclp_pkg::arg_word_t  args_q [6];
	logic [NOZZLES-1:0]   sel_q;
	logic [NOZZLES-1:0]   on_q;

	logic [7:0]           letter_n;
	logic                 viol_n;
	logic [1:0]           kind_n;
	logic [VW-1:0]        dval_n;
	logic [CW-1:0]        dcnt_n;
	logic [PW-1:0]        point_n;
	logic                 minus_n;
	logic [KW-1:0]        code_n;
	gclp_pkg::arg_word_t  args_n [6];
	logic [NOZZLES-1:0]   sel_n;
	logic [NOZZLES-1:0]   on_n;

	// Output register.
	logic                 out_valid_q;
	logic [KW-1:0]        cmd_q;
	gclp_pkg::arg_word_t  oarg_q [6];
	logic [MW-1:0]        mask_q;

	logic accept;
	logic is_flush;
	logic is_space;
	logic is_digit;
	logic [3:0] dig;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign is_flush = func || (char_in == gclp_pkg::CH_LF);
	assign is_space = !func && (char_in == gclp_pkg::CH_SP);
	assign is_digit = (char_in >= gclp_pkg::CH_0) && (char_in <= gclp_pkg::CH_9);
	assign dig = 4'(char_in - gclp_pkg::CH_0);

	// Decode of the open word's letter into an argument slot and tag.
	logic       is_axis;
	logic [2:0] slot;
	logic [1:0] tag;

	always_comb begin
		is_axis = 1'b1;
		slot = 3'd0;
		tag = 2'd1;
		unique case (letter_q)
			gclp_pkg::CH_X: slot = 3'd0;
			gclp_pkg::CH_Y: slot = 3'd1;
			gclp_pkg::CH_Z: slot = 3'd2;
			gclp_pkg::CH_E: slot = 3'd3;
			gclp_pkg::CH_F: slot = 3'd4;
			gclp_pkg::CH_S: slot = 3'd5;
			gclp_pkg::CH_I: begin
				slot = 3'd2;
				tag = 2'd2;
			end
			gclp_pkg::CH_P: begin
				slot = 3'd4;
				tag = 2'd2;
			end
			gclp_pkg::CH_J: begin
				slot = 3'd5;
				tag = 2'd3;
			end
			gclp_pkg::CH_R: begin
				slot = 3'd4;
				tag = 2'd0;
			end
			default: begin
				is_axis = 1'b0;
			end
		endcase
	end

	// Scale the decimal word to hundredths. Extra fraction digits are dropped through
	// reciprocal multiplies, exact for every value of the digit accumulator.
	logic [CW-1:0] frac;
	logic [34:0]   prod;
	logic [29:0]   scaled;
	logic [29:0]   low;

	always_comb begin
		frac = (point_q <= PW'(dcnt_q)) ? CW'(PW'(dcnt_q) - point_q) : '0;
		prod = '0;
		scaled = '0;
		if (point_q == gclp_pkg::NO_POINT) begin
			scaled = 30'(dval_q) * 30'd100;
		end else begin
			case (frac)
				3'd0: scaled = 30'(dval_q) * 30'd100;
				3'd1: scaled = 30'(dval_q) * 30'd10;
				3'd2: scaled = 30'(dval_q);
				3'd3: begin
					prod = 35'(dval_q) * 35'd52429;
					scaled = 30'(prod >> 19);
				end
				3'd4: begin
					prod = 35'(dval_q) * 35'd167773;
					scaled = 30'(prod >> 24);
				end
				3'd5: begin
					prod = 35'(dval_q) * 35'd134218;
					scaled = 30'(prod >> 27);
				end
				default: scaled = '0;
			endcase
		end
		low = minus_q ? (30'd0 - scaled) : scaled;
	end

	// Nozzle select hit for an N word.
	logic [NOZZLES-1:0] nhit;
	for (genvar i = 0; i < NOZZLES; i++) begin : g_nhit
		assign nhit[i] = (dval_q == VW'(i));
	end

	// Effect of closing the open word.
	logic [KW-1:0]        code_f;
	gclp_pkg::arg_word_t  args_f [6];
	logic [NOZZLES-1:0]   sel_f;
	logic [NOZZLES-1:0]   on_f;

	always_comb begin
		code_f = code_q;
		args_f = args_q;
		sel_f = sel_q;
		on_f = on_q;
		if (!viol_q) begin
			case (letter_q)
				gclp_pkg::CH_G: code_f = KW'(dval_q + VW'(gclp_pkg::G_OFFSET));
				gclp_pkg::CH_M: code_f = dval_q[KW-1:0];
				gclp_pkg::CH_N: sel_f = sel_q | nhit;
				gclp_pkg::CH_D: begin
					if (dval_q == '0) begin
						code_f = code_q - KW'(gclp_pkg::DIR0_DROP);
					end else if (dval_q == VW'(1)) begin
						code_f = code_q - KW'(gclp_pkg::DIR1_DROP);
					end
				end
				gclp_pkg::CH_T: begin
					if (dval_q == VW'(1)) begin
						on_f = on_q | sel_q;
					end else if (dval_q == '0) begin
						on_f = on_q & ~sel_q;
					end
				end
				default: begin
					if (is_axis) begin
						// A word without digits keeps the slot's value and only retags it.
						if (dcnt_q != '0) begin
							args_f[slot] = {tag, low};
						end else begin
							args_f[slot] = {tag, args_q[slot][29:0]};
						end
					end
				end
			endcase
		end
	end

	// Next parser state.
	logic          take;
	logic [CW-1:0] limit;

	always_comb begin
		letter_n = letter_q;
		viol_n = viol_q;
		kind_n = kind_q;
		dval_n = dval_q;
		dcnt_n = dcnt_q;
		point_n = point_q;
		minus_n = minus_q;
		code_n = code_q;
		args_n = args_q;
		sel_n = sel_q;
		on_n = on_q;
		take = 1'b0;
		limit = '0;
		if (is_flush || is_space) begin
			code_n = code_f;
			args_n = args_f;
			sel_n = sel_f;
			on_n = on_f;
			letter_n = gclp_pkg::CH_NUL;
			viol_n = 1'b0;
			dval_n = '0;
			dcnt_n = '0;
			point_n = gclp_pkg::NO_POINT;
			minus_n = 1'b0;
			if (is_flush) begin
				// A line that never got a kind clears the remembered nozzles.
				if (kind_q == gclp_pkg::KIND_NONE) begin
					on_n = '0;
				end
				kind_n = gclp_pkg::KIND_NONE;
				code_n = '0;
				for (int k = 0; k < 6; k++) begin
					args_n[k] = '0;
				end
				sel_n = '0;
			end
		end else if (letter_q == gclp_pkg::CH_NUL) begin
			// First character of a word: its letter, checked against the line kind.
			letter_n = char_in;
			case (char_in)
				gclp_pkg::CH_N: begin
					if (kind_q == gclp_pkg::KIND_NONE || kind_q == gclp_pkg::KIND_NOZZLE) begin
						kind_n = gclp_pkg::KIND_NOZZLE;
					end else begin
						viol_n = 1'b1;
					end
				end
				gclp_pkg::CH_G: begin
					if (kind_q == gclp_pkg::KIND_NONE) kind_n = gclp_pkg::KIND_G;
					else viol_n = 1'b1;
				end
				gclp_pkg::CH_M: begin
					if (kind_q == gclp_pkg::KIND_NONE) kind_n = gclp_pkg::KIND_M;
					else viol_n = 1'b1;
				end
				gclp_pkg::CH_D: begin
					if (kind_q != gclp_pkg::KIND_G) viol_n = 1'b1;
				end
				gclp_pkg::CH_T: begin
					if (kind_q != gclp_pkg::KIND_NOZZLE) viol_n = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (!viol_q) begin
			case (letter_q) inside
				gclp_pkg::CH_G, gclp_pkg::CH_M, gclp_pkg::CH_N: begin
					take = 1'b1;
					limit = gclp_pkg::LIM_CODE;
				end
				gclp_pkg::CH_D, gclp_pkg::CH_T: begin
					take = 1'b1;
					limit = gclp_pkg::LIM_FLAG;
				end
				default: begin
					if (is_axis) begin
						if (char_in == gclp_pkg::CH_MINUS) begin
							minus_n = 1'b1;
						end else if (char_in == gclp_pkg::CH_DOT) begin
							point_n = PW'(dcnt_q);
						end else begin
							take = 1'b1;
							limit = gclp_pkg::LIM_DEC;
						end
					end
				end
			endcase
			if (take) begin
				if (is_digit && (dcnt_q < limit)) begin
					dval_n = VW'(dval_q * VW'(10)) + VW'(dig);
					dcnt_n = dcnt_q + CW'(1);
				end else begin
					viol_n = 1'b1;
				end
			end
		end
	end

	// Record fields for a closing line, taken after the last word is closed.
	logic [MW-1:0] on_wide;
	for (genvar b = 0; b < MW; b++) begin : g_mask
		if (b < NOZZLES) begin : g_on
			assign on_wide[b] = on_f[b];
		end else begin : g_off
			assign on_wide[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= gclp_pkg::CH_NUL;
			viol_q <= 1'b0;
			kind_q <= gclp_pkg::KIND_NONE;
			dval_q <= '0;
			dcnt_q <= '0;
			point_q <= gclp_pkg::NO_POINT;
			minus_q <= 1'b0;
			code_q <= '0;
			args_q <= '{default: '0};
			sel_q <= '0;
			on_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				letter_q <= letter_n;
				viol_q <= viol_n;
				kind_q <= kind_n;
				dval_q <= dval_n;
				dcnt_q <= dcnt_n;
				point_q <= point_n;
				minus_q <= minus_n;
				code_q <= code_n;
				args_q <= args_n;
				sel_q <= sel_n;
				on_q <= on_n;
			end
			if (accept && is_flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register; loaded only when a line closes.
	always_ff @(posedge clk) begin
		if (accept && is_flush) begin
			cmd_q <= (kind_q == gclp_pkg::KIND_NOZZLE) ? KW'(gclp_pkg::NOZZLE_LINE_CODE) : code_f;
			for (int k = 0; k < 6; k++) begin
				oarg_q[k] <= (args_f[k][31:30] != 2'd0) ? args_f[k] : '0;
			end
			mask_q <= (kind_q == gclp_pkg::KIND_NOZZLE) ? on_wide : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign command_code = cmd_q;
	assign arg_word_1 = oarg_q[0];
	assign arg_word_2 = oarg_q[1];
	assign arg_word_3 = oarg_q[2];
	assign arg_word_4 = oarg_q[3];
	assign arg_word_5 = oarg_q[4];
	assign arg_word_6 = oarg_q[5];
	assign nozzle_mask = mask_q;

endmodule

`default_nettype wire

// ===== rtl/gclp_checker.sv =====
// Port-level checks of the G-code line parser, bound to its top level.
`default_nettype none

module gclp_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_valid,
	input wire                               in_ready,
	input wire                               func,
	input wire  [7:0]                        char_in,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire signed [gclp_pkg::CODE_W-1:0] command_code,
	input wire  [gclp_pkg::ARG_W-1:0]        arg_word_1,
	input wire  [gclp_pkg::ARG_W-1:0]        arg_word_2,
	input wire  [gclp_pkg::ARG_W-1:0]        arg_word_3,
	input wire  [gclp_pkg::ARG_W-1:0]        arg_word_4,
	input wire  [gclp_pkg::ARG_W-1:0]        arg_word_5,
	input wire  [gclp_pkg::ARG_W-1:0]        arg_word_6,
	input wire  [gclp_pkg::MASK_W-1:0]       nozzle_mask
);

	// A stalled record holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command_code) &&
		$stable(arg_word_1) && $stable(arg_word_5) && $stable(nozzle_mask))
		else $error("stalled record changed");

	// An empty output stage always takes a character.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A new record appears only after a line-closing transaction.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready &&
		(func || char_in == gclp_pkg::CH_LF)))
		else $error("record without a closing transaction");

	// A nonzero nozzle mask only comes with a nozzle line code.
	a_nozzle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nozzle_mask != '0 |->
		command_code == gclp_pkg::CODE_W'(gclp_pkg::NOZZLE_LINE_CODE))
		else $error("nozzle mask on a non-nozzle line");

	// An untagged argument slot reads as zero.
	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (arg_word_3[31:30] != 2'd0 || arg_word_3 == '0) &&
		(arg_word_5[31:30] != 2'd0 || arg_word_5 == '0) &&
		(arg_word_6[31:30] != 2'd0 || arg_word_6 == '0))
		else $error("untagged argument not zero");

endmodule

bind gcode_line_parser gclp_checker u_gclp_checker (.*);

`default_nettype wire
